// ===== rtl/scd_pkg.sv =====
// Shared types and constants of the serial command deframer.
package scd_pkg;

	// Framing bytes
	localparam logic [7:0] HEADER_BYTE   = 8'hA9;
	localparam logic [7:0] TYPE_ANGLES   = 8'h01;
	localparam logic [7:0] TYPE_RAW      = 8'h02;
	localparam logic [7:0] TYPE_GYRO_OFS = 8'h03;
	localparam logic [7:0] TYPE_MAG      = 8'h04;
	localparam logic [7:0] TYPE_STATUS   = 8'h05;
	localparam logic [7:0] TYPE_HALT     = 8'h06;
	localparam logic [7:0] TYPE_RESUME   = 8'h07;
	localparam logic [7:0] TYPE_GYRO_SCL = 8'h10;
	localparam logic [7:0] TYPE_RST_CAL  = 8'h11;
	localparam logic [7:0] TYPE_SYSRESET = 8'h12;

	// Payload block lengths, one bit wider than the 6-bit index
	localparam logic [6:0] SHORT_BLOCK_BYTES = 7'd12;
	localparam logic [6:0] LONG_BLOCK_BYTES  = 7'd48;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TYPE = 3'd1,
		PH_GOFF = 3'd2,
		PH_MAG  = 3'd3,
		PH_GSCL = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_ANGLES    = 4'd1,
		EV_RAW       = 4'd2,
		EV_STATUS    = 4'd3,
		EV_HALT      = 4'd4,
		EV_RESUME    = 4'd5,
		EV_RST_CAL   = 4'd6,
		EV_SYSRESET  = 4'd7,
		EV_GOFF_DONE = 4'd8,
		EV_MAG_DONE  = 4'd9,
		EV_GSCL_DONE = 4'd10
	} event_t;

endpackage

// ===== rtl/serial_command_deframer_top.sv =====
// Serial command deframer: header/type parser with payload byte indexing.
//
// Takes one received serial byte per request and returns exactly one result
// per byte. A frame starts with header 0xA9, followed by a type byte. Simple
// commands raise a one-shot event code on event_res; halt and resume also
// set or clear the kept halted level, which comes out of reset as halted and
// shows on output_halted with each result. Calibration types (0x03, 0x10:
// 12 bytes; 0x04: 48 bytes) stream their payload out as payload_valid/
// payload_index/payload_byte, with the completion event on the last byte.
// Unknown types drop back to idle, and a header seen inside a payload is
// taken as data. Throughput is one byte per clock cycle while the output is
// not stalled. A byte is taken into the input register (_s1) when accepted,
// and its result loads the result register (_s2) once the result side can
// take data, with the parser state updated on that same edge; the outputs
// are driven straight from _s2. The result register advances only when the
// result side can take data, and the input register takes a byte only when
// empty or advancing: back-pressure stalls the input without losing a byte.
module serial_command_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] event_res,
	output logic       payload_valid,
	output logic [5:0] payload_index,
	output logic [7:0] payload_byte,
	output logic       output_halted
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	scd_pkg::phase_t phase_q, phase_d;
	logic [5:0]      index_q, index_d;
	logic            halted_q, halted_d;

	// result stage
	logic       valid_s2;
	logic [3:0] event_s2;
	logic       pvalid_s2;
	logic [5:0] pindex_s2;
	logic [7:0] pbyte_s2;
	logic       halted_s2;

	// combinational results
	scd_pkg::event_t ev_d;
	logic            pvalid_d;
	logic [5:0]      pindex_d;
	logic [7:0]      pbyte_d;

	logic       advance;   // result stage can load
	logic       fire;      // byte in s1 is processed this cycle
	logic [6:0] count_nxt;
	logic [6:0] limit;
	logic       block_end;

	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	assign count_nxt = {1'b0, index_q} + 7'd1;
	assign limit     = (phase_q == scd_pkg::PH_MAG) ? scd_pkg::LONG_BLOCK_BYTES
	                                                : scd_pkg::SHORT_BLOCK_BYTES;
	assign block_end = (count_nxt >= limit);

	// Next-state logic
	always_comb begin
		phase_d = scd_pkg::PH_IDLE;
		index_d = index_q;
		unique case (phase_q)
			scd_pkg::PH_TYPE: begin
				unique case (byte_s1)
					scd_pkg::TYPE_GYRO_OFS: phase_d = scd_pkg::PH_GOFF;
					scd_pkg::TYPE_MAG:      phase_d = scd_pkg::PH_MAG;
					scd_pkg::TYPE_GYRO_SCL: phase_d = scd_pkg::PH_GSCL;
					default:                phase_d = scd_pkg::PH_IDLE;
				endcase
			end
			scd_pkg::PH_GOFF, scd_pkg::PH_MAG, scd_pkg::PH_GSCL: begin
				index_d = count_nxt[5:0];
				phase_d = block_end ? scd_pkg::PH_IDLE : phase_q;
			end
			default: begin
				// idle and unused codes: hunt for the header
				if (byte_s1 == scd_pkg::HEADER_BYTE) begin
					phase_d = scd_pkg::PH_TYPE;
					index_d = 6'd0;
				end
			end
		endcase
	end

	// Output logic
	always_comb begin
		ev_d     = scd_pkg::EV_NONE;
		pvalid_d = 1'b0;
		pindex_d = 6'd0;
		pbyte_d  = 8'd0;
		halted_d = halted_q;
		unique case (phase_q)
			scd_pkg::PH_TYPE: begin
				unique case (byte_s1)
					scd_pkg::TYPE_ANGLES:   ev_d = scd_pkg::EV_ANGLES;
					scd_pkg::TYPE_RAW:      ev_d = scd_pkg::EV_RAW;
					scd_pkg::TYPE_STATUS:   ev_d = scd_pkg::EV_STATUS;
					scd_pkg::TYPE_HALT: begin
						ev_d     = scd_pkg::EV_HALT;
						halted_d = 1'b1;
					end
					scd_pkg::TYPE_RESUME: begin
						ev_d     = scd_pkg::EV_RESUME;
						halted_d = 1'b0;
					end
					scd_pkg::TYPE_RST_CAL:  ev_d = scd_pkg::EV_RST_CAL;
					scd_pkg::TYPE_SYSRESET: ev_d = scd_pkg::EV_SYSRESET;
					default:                ev_d = scd_pkg::EV_NONE;
				endcase
			end
			scd_pkg::PH_GOFF, scd_pkg::PH_MAG, scd_pkg::PH_GSCL: begin
				pvalid_d = 1'b1;
				pindex_d = index_q;
				pbyte_d  = byte_s1;
				if (block_end) begin
					unique case (phase_q)
						scd_pkg::PH_GOFF: ev_d = scd_pkg::EV_GOFF_DONE;
						scd_pkg::PH_MAG:  ev_d = scd_pkg::EV_MAG_DONE;
						default:          ev_d = scd_pkg::EV_GSCL_DONE;
					endcase
				end
			end
			default: ev_d = scd_pkg::EV_NONE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= scd_pkg::PH_IDLE;
			index_q  <= 6'd0;
			halted_q <= 1'b1;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
			if (fire) begin
				phase_q  <= phase_d;
				index_q  <= index_d;
				halted_q <= halted_d;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= rx_byte;
		if (fire) begin
			event_s2  <= ev_d;
			pvalid_s2 <= pvalid_d;
			pindex_s2 <= pindex_d;
			pbyte_s2  <= pbyte_d;
			halted_s2 <= halted_d;
		end
	end

	assign out_valid     = valid_s2;
	assign event_res     = event_s2;
	assign payload_valid = pvalid_s2;
	assign payload_index = pindex_s2;
	assign payload_byte  = pbyte_s2;
	assign output_halted = halted_s2;

endmodule

// ===== rtl/scd_checker.sv =====
// Port-level checker for the serial command deframer, with its bind.
module scd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] event_res,
	input logic       payload_valid,
	input logic [5:0] payload_index,
	input logic [7:0] payload_byte,
	input logic       output_halted
);

	// non-payload results carry zero index and byte
	a_no_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_index == 6'd0 && payload_byte == 8'd0)
		else $error("payload fields nonzero without payload_valid");

	// completion events only come with a payload byte
	a_done_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == scd_pkg::EV_GOFF_DONE ||
		              event_res == scd_pkg::EV_MAG_DONE ||
		              event_res == scd_pkg::EV_GSCL_DONE) |-> payload_valid)
		else $error("completion event without payload byte");

	// halt and resume events show the level they set
	a_halt_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == scd_pkg::EV_HALT |-> output_halted)
		else $error("halt event with output not halted");

	a_resume_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == scd_pkg::EV_RESUME |-> !output_halted)
		else $error("resume event with output still halted");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) &&
		                            $stable(payload_byte) && $stable(payload_index))
		else $error("stalled result changed");

endmodule

bind serial_command_deframer_top scd_checker u_scd_checker (.*);
